/* rtl/core/fppc_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fppc_pkg: shared types and constants of the framed packet parser
// Frame size limits, CRC-16/CCITT-FALSE step, result codes and the
// command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package fppc_pkg;

	localparam int MAX_FRAME_BYTES = 32;
	localparam int MIN_FRAME_BYTES = 6;

	localparam int BYTE_W  = 8;
	localparam int CRC_W   = 16;
	localparam int LEN_W   = 6;                                   // length register width
	localparam int CNT_W   = $clog2(MAX_FRAME_BYTES + 1);         // holds 0..MAX
	localparam int IDX_W   = $clog2(MAX_FRAME_BYTES);             // store address
	localparam int BIDX_W  = 5;                                   // byte_index field
	localparam int OUTC_W  = 2;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	localparam logic [CRC_W-1:0] CRC_INIT = 16'hFFFF;
	localparam logic [CRC_W-1:0] CRC_POLY = 16'h1021;

	typedef enum logic [OUTC_W-1:0] {
		OUT_INVALID = 2'd0,
		OUT_DATA    = 2'd1,
		OUT_ACK     = 2'd2
	} outcome_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MAGIC    = 3'd0,
		REG_VERSION  = 3'd1,
		REG_DATA_CODE = 3'd2,
		REG_ACK_CODE = 3'd3,
		REG_DATA_LEN = 3'd4,
		REG_ACK_LEN  = 3'd5
	} cfg_reg_t;

	// controller -> datapath
	typedef struct packed {
		logic take;       // input item accepted this cycle
		logic rd;         // read frame store at replay index
		logic adv;        // replay item taken, step index
		logic show_fail;  // result channel carries the invalid item
	} ctrl_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic fail;       // current byte breaks the frame
		logic done;       // current byte closes a good frame
		logic rep_last;   // replay index is at the final byte
	} dp_stat_t;

	// one byte through the MSB-first CRC register
	function automatic logic [CRC_W-1:0] crc_add(input logic [CRC_W-1:0] crc,
		input logic [BYTE_W-1:0] b);
		logic [CRC_W-1:0] c;
		c = crc ^ {b, 8'h00};
		for (int k = 0; k < 8; k++) begin
			if (c[CRC_W-1]) begin
				c = {c[CRC_W-2:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[CRC_W-2:0], 1'b0};
			end
		end
		return c;
	endfunction

	function automatic logic [CNT_W-1:0] clamp_len(input logic [LEN_W-1:0] v);
		logic [CNT_W:0] w;
		w = (CNT_W + 1)'(v);
		if (w < (CNT_W + 1)'(MIN_FRAME_BYTES)) begin
			return CNT_W'(MIN_FRAME_BYTES);
		end
		if (w > (CNT_W + 1)'(MAX_FRAME_BYTES)) begin
			return CNT_W'(MAX_FRAME_BYTES);
		end
		return CNT_W'(w);
	endfunction

endpackage
`default_nettype wire

/* rtl/core/fppc_ifs.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fppc_ifs: valid/ready channels of the framed packet parser
// Received byte channel and result channel.
// ----------------------------------------------------------------------------
interface fppc_byte_if;
	import fppc_pkg::*;
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] rx_byte;
	modport source (output valid, output rx_byte, input ready);
	modport sink   (input valid, input rx_byte, output ready);
endinterface

interface fppc_res_if;
	import fppc_pkg::*;
	logic              valid;
	logic              ready;
	logic [OUTC_W-1:0] outcome;
	logic [BIDX_W-1:0] byte_index;
	logic [BYTE_W-1:0] frame_byte;
	logic              last;
	modport source (output valid, output outcome, output byte_index, output frame_byte,
		output last, input ready);
	modport sink   (input valid, input outcome, input byte_index, input frame_byte,
		input last, output ready);
endinterface
`default_nettype wire

/* rtl/core/fppc_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fppc_ctrl: parser controller
// Receive, invalid report, and store replay sequencing.
// ----------------------------------------------------------------------------
module fppc_ctrl (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  in_valid,
	output logic                 in_ready,
	output logic                 out_valid,
	input  wire                  out_ready,
	input  fppc_pkg::dp_stat_t   stat,
	output fppc_pkg::ctrl_cmd_t  cmd
);
	import fppc_pkg::*;

	typedef enum logic [3:0] {
		S_RX   = 4'b0001,
		S_FAIL = 4'b0010,
		S_RD   = 4'b0100,
		S_EMIT = 4'b1000
	} state_t;

	state_t state_q, state_d;

	always_comb begin
		in_ready      = (state_q == S_RX);
		out_valid     = (state_q == S_FAIL) || (state_q == S_EMIT);
		cmd.take      = (state_q == S_RX) && in_valid;
		cmd.rd        = (state_q == S_RD);
		cmd.adv       = (state_q == S_EMIT) && out_ready;
		cmd.show_fail = (state_q == S_FAIL);
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_RX: begin
				if (in_valid && stat.fail) begin
					state_d = S_FAIL;
				end else if (in_valid && stat.done) begin
					state_d = S_RD;
				end
			end
			S_FAIL: begin
				if (out_ready) state_d = S_RX;
			end
			S_RD: begin
				state_d = S_EMIT;
			end
			S_EMIT: begin
				if (out_ready) state_d = stat.rep_last ? S_RX : S_RD;
			end
			default: begin
				state_d = S_RX;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_RX;
		end else begin
			state_q <= state_d;
		end
	end

endmodule
`default_nettype wire

/* rtl/core/fppc_dp.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fppc_dp: parser datapath
// Config registers, frame store, header checks, running CRC, replay output.
// ----------------------------------------------------------------------------
module fppc_dp (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              cfg_we,
	input  wire [fppc_pkg::CFG_IDX_W-1:0]    cfg_idx,
	input  wire [fppc_pkg::CFG_DATA_W-1:0]   cfg_wdata,
	input  wire [fppc_pkg::BYTE_W-1:0]       rx_byte,
	input  fppc_pkg::ctrl_cmd_t              cmd,
	output fppc_pkg::dp_stat_t               stat,
	output logic [fppc_pkg::OUTC_W-1:0]      outcome,
	output logic [fppc_pkg::BIDX_W-1:0]      byte_index,
	output logic [fppc_pkg::BYTE_W-1:0]      frame_byte,
	output logic                             last
);
	import fppc_pkg::*;

	// configuration
	logic [15:0]       magic_q;
	logic [BYTE_W-1:0] ver_q, dcode_q, acode_q;
	logic [LEN_W-1:0]  dlen_q, alen_q;

	// frame tracking
	logic [CNT_W-1:0]  cnt_q, exp_q, len_q;
	logic [CRC_W-1:0]  crc_q;
	logic [IDX_W-1:0]  idx_q;
	outcome_t          kind_q;
	logic [BYTE_W-1:0] hdr_q [4];
	logic [BYTE_W-1:0] prev_q, rd_q;
	logic [BYTE_W-1:0] mem [MAX_FRAME_BYTES];

	logic [BYTE_W-1:0] lo, hi;
	logic [CNT_W-1:0]  cnt_inc;
	logic              hunting, ovf, b_is_lo, is_data, is_ack;
	logic              hdr_fail, reach, code_ok, chk_ok, crc_upd;
	logic              restart, wr_en;
	logic [IDX_W-1:0]  wr_addr;
	outcome_t          kind_d;

	always_comb begin
		lo       = magic_q[7:0];
		hi       = magic_q[15:8];
		cnt_inc  = cnt_q + CNT_W'(1);
		hunting  = (cnt_q == '0);
		ovf      = (cnt_q >= CNT_W'(MAX_FRAME_BYTES));
		b_is_lo  = (rx_byte == lo);
		is_data  = (rx_byte == dcode_q);
		is_ack   = (rx_byte == acode_q);
		hdr_fail = ((cnt_inc == CNT_W'(2)) && (rx_byte != hi)) ||
			((cnt_inc == CNT_W'(4)) && ((hdr_q[2] != ver_q) || (!is_data && !is_ack)));
		reach    = (exp_q != '0) && (cnt_inc >= exp_q);
		kind_d   = (hdr_q[3] == dcode_q) ? OUT_DATA : OUT_ACK;
		code_ok  = (hdr_q[3] == dcode_q) || (hdr_q[3] == acode_q);
		// trailing two bytes carry the CRC, low byte first
		chk_ok   = (hdr_q[0] == lo) && (hdr_q[1] == hi) && (hdr_q[2] == ver_q) &&
			code_ok && ({rx_byte, prev_q} == crc_q);
		crc_upd  = (exp_q == '0) || (({1'b0, cnt_q} + (CNT_W + 1)'(2)) < {1'b0, exp_q});

		stat.fail     = !hunting && (ovf || hdr_fail || (reach && !chk_ok));
		stat.done     = !hunting && !ovf && !hdr_fail && reach && chk_ok;
		stat.rep_last = ((CNT_W'(idx_q) + CNT_W'(1)) == len_q);

		restart  = hunting || stat.fail;
		wr_en    = cmd.take && (restart ? b_is_lo : 1'b1);
		wr_addr  = restart ? '0 : cnt_q[IDX_W-1:0];
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			magic_q <= '0;
			ver_q   <= '0;
			dcode_q <= '0;
			acode_q <= 8'd1;
			dlen_q  <= 6'd32;
			alen_q  <= 6'd8;
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_MAGIC:     magic_q <= cfg_wdata;
				REG_VERSION:   ver_q   <= cfg_wdata[BYTE_W-1:0];
				REG_DATA_CODE: dcode_q <= cfg_wdata[BYTE_W-1:0];
				REG_ACK_CODE:  acode_q <= cfg_wdata[BYTE_W-1:0];
				REG_DATA_LEN:  dlen_q  <= cfg_wdata[LEN_W-1:0];
				REG_ACK_LEN:   alen_q  <= cfg_wdata[LEN_W-1:0];
				default: ;
			endcase
		end
	end

	// frame tracking
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			exp_q  <= '0;
			crc_q  <= CRC_INIT;
			idx_q  <= '0;
			len_q  <= '0;
			kind_q <= OUT_DATA;
		end else begin
			if (cmd.take) begin
				if (restart) begin
					exp_q <= '0;
					cnt_q <= b_is_lo ? CNT_W'(1) : '0;
					crc_q <= b_is_lo ? crc_add(CRC_INIT, rx_byte) : CRC_INIT;
				end else if (stat.done) begin
					cnt_q  <= '0;
					exp_q  <= '0;
					crc_q  <= CRC_INIT;
					len_q  <= exp_q;
					kind_q <= kind_d;
					idx_q  <= '0;
				end else begin
					cnt_q <= cnt_inc;
					if (crc_upd) crc_q <= crc_add(crc_q, rx_byte);
					if (cnt_q == CNT_W'(3)) begin
						exp_q <= is_data ? clamp_len(dlen_q) : clamp_len(alen_q);
					end
				end
			end
			if (cmd.adv) idx_q <= idx_q + IDX_W'(1);
		end
	end

	// frame store and header copy
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= rx_byte;
			prev_q       <= rx_byte;
			if (cnt_q < CNT_W'(4) || restart) hdr_q[wr_addr[1:0]] <= rx_byte;
		end
		if (cmd.rd) rd_q <= mem[idx_q];
	end

	always_comb begin
		if (cmd.show_fail) begin
			outcome    = OUT_INVALID;
			byte_index = '0;
			frame_byte = '0;
			last       = 1'b1;
		end else begin
			outcome    = kind_q;
			byte_index = BIDX_W'(idx_q);
			frame_byte = rd_q;
			last       = stat.rep_last;
		end
	end

endmodule
`default_nettype wire

/* rtl/core/framed_packet_parser_crc16.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// framed_packet_parser_crc16: sync-word framed packet parser, CRC-16 check
// Hunts for the sync word, checks version and type, keeps a running
// CRC-16/CCITT-FALSE and replays each good frame byte by byte.
// ----------------------------------------------------------------------------
//  channel   dir   handshake       payload
//  rx        in    valid/ready     rx_byte
//  res       out   valid/ready     outcome, byte_index, frame_byte, last
//  cfg       in    cfg_we only     cfg_idx, cfg_wdata
//
//  One received byte per cycle while receiving; CRC step and header checks
//  act on the byte as it is taken. A bad frame holds the input while its
//  invalid item waits. A good frame replays from the store (S_RD reads, then
//  S_EMIT presents each item) and holds the input until replay is done.
//  Reset (arst_n low) clears the parser to hunting and loads register defaults;
//  the frame store is not cleared, only bytes written in the frame are read.
// ----------------------------------------------------------------------------
module framed_packet_parser_crc16 (
	input  wire                              clk,
	input  wire                              arst_n,
	fppc_byte_if.sink                        rx,
	fppc_res_if.source                       res,
	input  wire                              cfg_we,
	input  wire [fppc_pkg::CFG_IDX_W-1:0]    cfg_idx,
	input  wire [fppc_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
	import fppc_pkg::*;

	ctrl_cmd_t cmd;
	dp_stat_t  stat;

	// sequencing: receive / invalid report / replay
	fppc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (rx.valid),
		.in_ready  (rx.ready),
		.out_valid (res.valid),
		.out_ready (res.ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	// registers, frame store, checks and result payload
	fppc_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_idx    (cfg_idx),
		.cfg_wdata  (cfg_wdata),
		.rx_byte    (rx.rx_byte),
		.cmd        (cmd),
		.stat       (stat),
		.outcome    (res.outcome),
		.byte_index (res.byte_index),
		.frame_byte (res.frame_byte),
		.last       (res.last)
	);

endmodule
`default_nettype wire

/* tb/framed_packet_parser_crc16_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// framed_packet_parser_crc16_test: self-checking bench for the framed parser
// Feeds received bytes over the rx channel: a few hand-picked sequences at the
// reset register values, then register settings with well-formed frames,
// broken frames and line noise. A frame tracker mirrors the parser, queues the
// items each byte should release and checks every result item in order.
// ----------------------------------------------------------------------------
module framed_packet_parser_crc16_test;
	import fppc_pkg::*;

	localparam int unsigned CLK_HALF      = 2;       // 4 ns period
	localparam int unsigned RESET_CYCLES  = 8;
	localparam int unsigned RUN_LIMIT     = 300000;  // whole-run watchdog, in cycles
	localparam int unsigned DRAIN_LIMIT   = 5000;    // wait for a full replay under stalls
	localparam int unsigned SETTLE_CYCLES = 8;       // lets the parser finish its last byte
	localparam int unsigned NUM_PHASES    = 6;
	localparam int unsigned PHASE_BYTES   = 24;

	// index with no register behind it; writes must be dropped
	localparam logic [CFG_IDX_W-1:0] IDX_SPARE = 3'd7;

	// ways a generated frame can be spoiled
	typedef enum int unsigned {
		FLT_NONE,
		FLT_SYNC,     // second sync byte wrong
		FLT_VERSION,  // version byte wrong
		FLT_TYPE,     // type byte matches neither code
		FLT_CRC,      // one CRC byte flipped
		FLT_CUT       // frame stops early, the next bytes run on into it
	} frame_fault_t;

	// one result item as it should appear on the res channel
	typedef struct {
		outcome_t              outcome;
		logic [BIDX_W-1:0]     byte_index;
		logic [BYTE_W-1:0]     frame_byte;
		logic                  last;
	} frame_item_t;

	// ------------------------------------------------------------------------
	// Frame tracker: register copy, parser state, queue of awaited items
	// ------------------------------------------------------------------------
	class frame_tracker;
		logic [15:0]       magic;
		logic [7:0]        version;
		logic [7:0]        data_code;
		logic [7:0]        ack_code;
		logic [LEN_W-1:0]  data_len;
		logic [LEN_W-1:0]  ack_len;

		logic [7:0]        held [MAX_FRAME_BYTES];
		int unsigned       count;
		int unsigned       frame_len;   // 0 until the type byte is in
		logic [15:0]       crc;

		frame_item_t       replay_q [$];
		int unsigned       errors;
		int unsigned       items_seen;
		int unsigned       frames_good;
		int unsigned       rejects;

		function new();
			magic     = 16'h0000;
			version   = 8'h00;
			data_code = 8'h00;
			ack_code  = 8'h01;
			data_len  = 6'd32;
			ack_len   = 6'd8;
			foreach (held[i]) held[i] = 8'h00;
			errors = 0;
			items_seen = 0;
			frames_good = 0;
			rejects = 0;
			restart_hunt();
		endfunction

		function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] v);
			case (idx)
				REG_MAGIC:     magic     = v;
				REG_VERSION:   version   = v[7:0];
				REG_DATA_CODE: data_code = v[7:0];
				REG_ACK_CODE:  ack_code  = v[7:0];
				REG_DATA_LEN:  data_len  = v[LEN_W-1:0];
				REG_ACK_LEN:   ack_len   = v[LEN_W-1:0];
				default: ;
			endcase
		endfunction

		// MSB-first CRC-16, one byte, bitwise
		function logic [15:0] crc_ccitt_byte(logic [15:0] c, logic [7:0] b);
			logic [15:0] r;
			int unsigned k;
			r = c;
			for (k = 0; k < 8; k++) begin
				if (r[15] ^ b[7-k]) begin
					r = (r << 1) ^ CRC_POLY;
				end else begin
					r = r << 1;
				end
			end
			return r;
		endfunction

		function int unsigned eff_len(logic [LEN_W-1:0] v);
			if (v < MIN_FRAME_BYTES) return MIN_FRAME_BYTES;
			if (v > MAX_FRAME_BYTES) return MAX_FRAME_BYTES;
			return 32'(v);
		endfunction

		function void restart_hunt();
			count = 0;
			frame_len = 0;
			crc = CRC_INIT;
		endfunction

		// CRC runs over everything but the two trailing CRC bytes
		function void keep_byte(logic [7:0] b);
			if (count < MAX_FRAME_BYTES) begin
				held[count] = b;
				if (frame_len == 0 || count + 2 < frame_len) crc = crc_ccitt_byte(crc, b);
				count++;
			end
		endfunction

		// one invalid item; a byte equal to the sync low byte opens the next frame
		function void reject_frame(logic [7:0] b);
			frame_item_t it;
			restart_hunt();
			if (b == magic[7:0]) keep_byte(b);
			it.outcome = OUT_INVALID;
			it.byte_index = '0;
			it.frame_byte = '0;
			it.last = 1'b1;
			replay_q.push_back(it);
			rejects++;
		endfunction

		function void take_rx_byte(logic [7:0] b);
			frame_item_t it;
			outcome_t    kind;
			logic [7:0]  code;
			logic        ok;
			int unsigned i;
			if (count == 0) begin
				if (b == magic[7:0]) keep_byte(b);
				return;
			end
			if (count >= MAX_FRAME_BYTES) begin
				reject_frame(b);
				return;
			end
			keep_byte(b);
			if (count == 2 && held[1] != magic[15:8]) begin
				reject_frame(b);
				return;
			end
			if (count == 4) begin
				if (held[2] != version) begin
					reject_frame(b);
					return;
				end
				// data code is tried first, so equal codes give a data frame
				if (held[3] == data_code) begin
					frame_len = eff_len(data_len);
				end else if (held[3] == ack_code) begin
					frame_len = eff_len(ack_len);
				end else begin
					reject_frame(b);
					return;
				end
			end
			if (frame_len == 0 || count < frame_len) return;

			// closing byte: header checked again against the registers as they are now
			kind = (held[3] == data_code) ? OUT_DATA : OUT_ACK;
			code = (kind == OUT_DATA) ? data_code : ack_code;
			ok = held[0] == magic[7:0] && held[1] == magic[15:8] && held[2] == version &&
				held[3] == code && {held[frame_len-1], held[frame_len-2]} == crc;
			if (!ok) begin
				reject_frame(b);
				return;
			end
			for (i = 0; i < frame_len; i++) begin
				it.outcome = kind;
				it.byte_index = BIDX_W'(i);
				it.frame_byte = held[i];
				it.last = (i + 1 == frame_len);
				replay_q.push_back(it);
			end
			frames_good++;
			restart_hunt();
		endfunction

		task report(string what);
			errors++;
			$display("[%0t] MISMATCH %s", $time, what);
		endtask

		task check_item(logic [OUTC_W-1:0] oc, logic [BIDX_W-1:0] bi, logic [7:0] fbyte,
			logic lst);
			frame_item_t want;
			items_seen++;
			if (replay_q.size() == 0) begin
				report($sformatf("item %0d not awaited: outcome %0d index %0d byte %02h last %0b",
					items_seen, oc, bi, fbyte, lst));
				return;
			end
			want = replay_q.pop_front();
			if (oc !== want.outcome)
				report($sformatf("item %0d outcome %0d, want %0d", items_seen, oc, want.outcome));
			if (bi !== want.byte_index)
				report($sformatf("item %0d byte_index %0d, want %0d", items_seen, bi,
					want.byte_index));
			if (fbyte !== want.frame_byte)
				report($sformatf("item %0d frame_byte %02h, want %02h", items_seen, fbyte,
					want.frame_byte));
			if (lst !== want.last)
				report($sformatf("item %0d last %0b, want %0b", items_seen, lst, want.last));
		endtask

		task flush_leftover();
			foreach (replay_q[i])
				report($sformatf("item never came: outcome %0d index %0d byte %02h",
					replay_q[i].outcome, replay_q[i].byte_index, replay_q[i].frame_byte));
			replay_q.delete();
		endtask
	endclass

	// ------------------------------------------------------------------------
	// Clock, reset, channels, block
	// ------------------------------------------------------------------------
	logic clk = 1'b0;
	logic arst_n;
	logic                   cfg_we;
	logic [CFG_IDX_W-1:0]   cfg_idx;
	logic [CFG_DATA_W-1:0]  cfg_wdata;

	always #(CLK_HALF) clk = ~clk;

	fppc_byte_if rx_ch ();
	fppc_res_if  res_ch ();

	framed_packet_parser_crc16 u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.rx        (rx_ch),
		.res       (res_ch),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata)
	);

	frame_tracker trk;

	bit          rx_burst;      // no gaps on the rx side during this phase
	bit          res_burst;     // result side never stalls during this phase
	int unsigned res_hold;
	int unsigned bytes_sent;
	int unsigned rx_taken;
	int unsigned reg_sets;
	int unsigned cycle_count;

	// Mostly back to back, some short gaps, the odd long one.
	function automatic int unsigned pick_gap(bit burst);
		int unsigned r;
		if (burst) return 0;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 85) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// Result-side back-pressure. A chosen gap holds ready low until it runs out.
	always @(posedge clk) begin
		if (res_hold != 0) begin
			res_hold = res_hold - 1;
			res_ch.ready <= 1'b0;
		end else if (res_burst) begin
			res_ch.ready <= 1'b1;
		end else begin
			res_hold = pick_gap(1'b0);
			res_ch.ready <= (res_hold == 0);
			if (res_hold != 0) res_hold = res_hold - 1;
		end
	end

	// Both handshakes are seen in one process, input first. The parser never has
	// ready and a result item up at once, so the two never fire at the same edge.
	always @(posedge clk) begin
		if (arst_n) begin
			if (rx_ch.valid && rx_ch.ready) begin
				trk.take_rx_byte(rx_ch.rx_byte);
				rx_taken++;
			end
			if (res_ch.valid && res_ch.ready)
				trk.check_item(res_ch.outcome, res_ch.byte_index, res_ch.frame_byte,
					res_ch.last);
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == RUN_LIMIT) begin
			$display("framed_packet_parser_crc16_test: errors");
			$finish;
		end
	end

	// ------------------------------------------------------------------------
	// Drivers
	// ------------------------------------------------------------------------

	// One byte on rx. Valid stays up across back-to-back items; it only drops
	// when a gap is chosen, so it never gets two updates in one step.
	task automatic push_byte(input logic [7:0] b);
		int unsigned gap;
		rx_ch.valid   <= 1'b1;
		rx_ch.rx_byte <= b;
		@(posedge clk);
		while (!rx_ch.ready) @(posedge clk);
		bytes_sent++;
		gap = pick_gap(rx_burst);
		if (gap != 0) begin
			rx_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Stop sending, let every awaited item arrive, then let the parser settle
	// so it finishes its last byte. Anything still awaited is a failure.
	// It waits for a clock edge first, so the byte taken before has been tracked.
	task automatic drain();
		int unsigned waited;
		rx_ch.valid <= 1'b0;
		waited = 0;
		@(posedge clk);
		while (trk.replay_q.size() != 0 && waited < DRAIN_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (trk.replay_q.size() != 0) trk.flush_leftover();
	endtask

	// cfg_we is left high; the caller drops it after the last write.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] v);
		cfg_we    <= 1'b1;
		cfg_idx   <= idx;
		cfg_wdata <= v;
		@(posedge clk);
		trk.set_reg(idx, v);
	endtask

	// All six registers; bits above each register's width carry junk that the
	// block has to ignore.
	task automatic apply_config(input logic [15:0] mw, input logic [7:0] ver,
		input logic [7:0] dc, input logic [7:0] ac, input logic [5:0] dl,
		input logic [5:0] al);
		logic [7:0] junk8;
		logic [9:0] junk10;
		junk8 = 8'($urandom_range(0, 255));
		junk10 = 10'($urandom_range(0, 1023));
		write_reg(REG_MAGIC, mw);
		write_reg(REG_VERSION, {junk8, ver});
		write_reg(REG_DATA_CODE, {~junk8, dc});
		write_reg(REG_ACK_CODE, {junk8 ^ 8'h5A, ac});
		write_reg(REG_DATA_LEN, {junk10, dl});
		write_reg(REG_ACK_LEN, {~junk10, al});
		cfg_we <= 1'b0;
		reg_sets++;
	endtask

	// Random register values; lengths drawn from the given ranges.
	task automatic apply_random_config(input int unsigned dl_lo, input int unsigned dl_hi,
		input int unsigned al_lo, input int unsigned al_hi);
		apply_config(16'($urandom_range(0, 65535)), 8'($urandom_range(0, 255)),
			8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
			6'($urandom_range(dl_lo, dl_hi)), 6'($urandom_range(al_lo, al_hi)));
	endtask

	// Builds a frame from the registers as they stand, with a correct CRC,
	// then spoils it as asked. Payload now and then holds the sync low byte,
	// which must mean nothing inside a frame.
	task automatic send_frame(input logic want_ack, input frame_fault_t fault);
		logic [7:0]  fb [MAX_FRAME_BYTES];
		logic [7:0]  code;
		logic [7:0]  flip;
		logic [15:0] sum;
		int unsigned len;
		int unsigned n;
		int unsigned i;
		code = want_ack ? trk.ack_code : trk.data_code;
		len = (code == trk.data_code) ? trk.eff_len(trk.data_len) : trk.eff_len(trk.ack_len);
		flip = 8'($urandom_range(1, 255));
		fb[0] = trk.magic[7:0];
		fb[1] = trk.magic[15:8];
		fb[2] = trk.version;
		fb[3] = code;
		for (i = 4; i < len - 2; i++)
			fb[i] = ($urandom_range(0, 7) == 0) ? trk.magic[7:0] : 8'($urandom_range(0, 255));
		sum = CRC_INIT;
		for (i = 0; i < len - 2; i++) sum = trk.crc_ccitt_byte(sum, fb[i]);
		fb[len-2] = sum[7:0];
		fb[len-1] = sum[15:8];
		case (fault)
			FLT_SYNC:    fb[1] = fb[1] ^ flip;
			FLT_VERSION: fb[2] = fb[2] ^ flip;
			FLT_TYPE: begin
				fb[3] = 8'($urandom_range(0, 255));
				while (fb[3] == trk.data_code || fb[3] == trk.ack_code) fb[3] = fb[3] + 8'd1;
			end
			FLT_CRC:     fb[len - 1 - $urandom_range(0, 1)] ^= flip;
			default: ;
		endcase
		n = (fault == FLT_CUT) ? $urandom_range(1, len - 1) : len;
		for (i = 0; i < n; i++) push_byte(fb[i]);
	endtask

	// Line noise; a quarter of it is the sync low byte, which opens a frame.
	task automatic send_noise(input int unsigned n);
		repeat (n) begin
			if ($urandom_range(0, 3) == 0) begin
				push_byte(trk.magic[7:0]);
			end else begin
				push_byte(8'($urandom_range(0, 255)));
			end
		end
	endtask

	// Mostly clean frames with random payload, the rest broken frames and noise.
	task automatic run_phase(input int unsigned budget);
		int unsigned start;
		int unsigned r;
		logic want_ack;
		start = bytes_sent;
		while (bytes_sent - start < budget) begin
			r = $urandom_range(0, 99);
			want_ack = 1'($urandom_range(0, 1));
			if (r < 55) begin
				send_frame(want_ack, FLT_NONE);
			end else if (r < 85) begin
				send_frame(want_ack, frame_fault_t'($urandom_range(FLT_SYNC, FLT_CUT)));
			end else begin
				send_noise($urandom_range(1, 4));
			end
		end
	endtask

	// ------------------------------------------------------------------------
	// Stimulus
	// ------------------------------------------------------------------------
	initial begin
		logic [7:0]  x;
		logic [7:0]  c;
		int unsigned ph;
		arst_n        = 1'b0;
		cfg_we        = 1'b0;
		cfg_idx       = REG_MAGIC;
		cfg_wdata     = '0;
		rx_ch.valid   = 1'b0;
		rx_ch.rx_byte = '0;
		res_ch.ready  = 1'b0;
		res_hold      = 0;
		rx_burst      = 1'b0;
		res_burst     = 1'b0;
		bytes_sent    = 0;
		rx_taken      = 0;
		reg_sets      = 0;
		cycle_count   = 0;
		trk = new();

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Hand-picked sequences at the reset register values
		// (sync 0000, version 00, data code 00, ack code 01, lengths 32 / 8).
		push_byte(8'hFF);                          // hunting: dropped
		push_byte(8'h80);
		send_frame(1'b1, FLT_NONE);                // good 8-byte ack frame
		push_byte(trk.magic[7:0]);                 // broken sync word
		push_byte(trk.magic[15:8] ^ 8'h55);
		push_byte(trk.magic[7:0]);                 // bad version; the failing byte is
		push_byte(trk.magic[15:8]);                // the sync low byte, so it opens
		push_byte(trk.version ^ 8'h05);            // the next frame at once
		push_byte(trk.magic[7:0]);
		push_byte(trk.magic[15:8]);                // rest of an ack frame on that byte,
		push_byte(trk.version);                    // random body and CRC
		push_byte(trk.ack_code);
		repeat (4) push_byte(8'($urandom_range(0, 255)));
		drain();

		// Register settings. Half the time a frame is left open across the
		// change, so the header is judged again with the new values while the
		// latched length stays.
		for (ph = 0; ph < NUM_PHASES; ph++) begin
			if ($urandom_range(0, 1) == 1) send_frame(1'($urandom_range(0, 1)), FLT_CUT);
			drain();
			case (ph)
				0: apply_random_config(6, 12, 6, 12);
				// all-ones header; data length clamps to 32, ack length to 6
				1: apply_config(16'hFFFF, 8'hFF, 8'hFF, 8'h00, 6'd63, 6'd0);
				// equal type codes, sync bytes alike; lengths just outside the range
				2: begin
					x = 8'($urandom_range(0, 255));
					c = 8'($urandom_range(0, 255));
					apply_config({x, x}, 8'($urandom_range(0, 255)), c, c, 6'd5, 6'd33);
				end
				// spare index first, then all-zero header with both length limits
				3: begin
					write_reg(IDX_SPARE, 16'hFFFF);
					apply_config(16'h0000, 8'h00, 8'h00, 8'h01, 6'd6, 6'd32);
				end
				4: apply_random_config(6, 20, 6, 20);
				default: apply_random_config(0, 63, 6, 12);
			endcase
			rx_burst  = (ph == 2);
			res_burst = (ph == 4);
			run_phase(PHASE_BYTES);
		end
		drain();

		$display("run: %0d bytes taken, %0d result items, %0d good frames, %0d rejects",
			rx_taken, trk.items_seen, trk.frames_good, trk.rejects);
		$display("run: %0d register settings after the reset values, %0d mismatches",
			reg_sets, trk.errors);
		if (trk.errors == 0) begin
			$display("framed_packet_parser_crc16_test: clean");
		end else begin
			$display("framed_packet_parser_crc16_test: errors");
		end
		$finish;
	end

endmodule

/* files.f */
rtl/core/fppc_pkg.sv
rtl/core/fppc_ifs.sv
rtl/core/fppc_ctrl.sv
rtl/core/fppc_dp.sv
rtl/core/framed_packet_parser_crc16.sv
tb/framed_packet_parser_crc16_test.sv
